// ===== design/bss_pkg.sv =====
// ----------------------------------------------------------------------------
// bss_pkg
// Shared types and constants for the blend segment select block: the
// breakpoint count, the weight format, register indexes and sequencer states.
// ----------------------------------------------------------------------------
package bss_pkg;

   localparam int MAX_POSES        = 7;
   localparam int WEIGHT_FRAC_BITS = 16;

   localparam int PARAM_W     = 16;
   localparam int WEIGHT_W    = WEIGHT_FRAC_BITS + 1;
   localparam int POSE_CNT_W  = $clog2(MAX_POSES + 1);
   localparam int POSE_IDX_W  = $clog2(MAX_POSES);
   localparam int CSR_INDEX_W = $clog2(MAX_POSES + 1);
   localparam int CSR_DATA_W  = 16;
   localparam int POSE_FLD_W  = 3;
   localparam int DIV_CNT_W   = $clog2(WEIGHT_FRAC_BITS + 1);

   localparam logic [CSR_INDEX_W-1:0] CSR_POSE_COUNT   = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_BREAKPOINT_0 = CSR_INDEX_W'(1);

   localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = {1'b1, {WEIGHT_FRAC_BITS{1'b0}}};

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DIV,
      ST_DONE
   } state_type;

endpackage

// ===== design/bss_div.sv =====
// ----------------------------------------------------------------------------
// bss_div
// Restoring divider that forms floor((num << WEIGHT_FRAC_BITS) / den) one
// quotient bit per cycle, for num below den.
// ----------------------------------------------------------------------------
module bss_div (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic [bss_pkg::PARAM_W-1:0]          num,
   input  logic [bss_pkg::PARAM_W-1:0]          den,
   output logic                                 done,
   output logic [bss_pkg::WEIGHT_FRAC_BITS-1:0] quot
);
   import bss_pkg::*;

   logic                        busy_ff;
   logic                        done_ff;
   logic [DIV_CNT_W-1:0]        cnt_ff;
   logic [PARAM_W-1:0]          rem_ff;
   logic [PARAM_W-1:0]          den_ff;
   logic [WEIGHT_FRAC_BITS-1:0] quot_ff;

   logic [PARAM_W:0]   shifted;
   logic [PARAM_W:0]   diff;
   logic               fits;

   // The remainder stays below the divisor, so the shifted value fits in one
   // extra bit and a single trial subtraction decides each quotient bit.
   assign shifted = {rem_ff, 1'b0};
   assign diff    = shifted - {1'b0, den_ff};
   assign fits    = (shifted >= {1'b0, den_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= DIV_CNT_W'(WEIGHT_FRAC_BITS);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == DIV_CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff  <= num;
         den_ff  <= den;
         quot_ff <= '0;
      end else if (busy_ff) begin
         rem_ff  <= fits ? diff[PARAM_W-1:0] : shifted[PARAM_W-1:0];
         quot_ff <= {quot_ff[WEIGHT_FRAC_BITS-2:0], fits};
      end
   end

   assign done = done_ff;
   assign quot = quot_ff;

endmodule

// ===== design/blend_segment_select.sv =====
// ----------------------------------------------------------------------------
// blend_segment_select
// Finds the blend segment for a Q8.8 parameter and its Q1.16 weight.
// ----------------------------------------------------------------------------
// One transaction is taken at a time. A parameter equal to the previous one
// returns the held selection: the sequencer goes from idle straight to the
// done state and then loads the output register. Otherwise the sequencer walks
// the breakpoints one per cycle, comparing one breakpoint at a time, and a
// blend between two poses then goes through the restoring divider.
// The request side is stalled until the result has been moved into the output
// register; the result may wait there while the next transaction is accepted.
module blend_segment_select (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_wr_en,
   input  logic [bss_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [bss_pkg::CSR_DATA_W-1:0]        csr_wdata,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic signed [bss_pkg::PARAM_W-1:0]    req_blend_param,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic                                  rsp_two_poses,
   output logic [bss_pkg::POSE_FLD_W-1:0]        rsp_source_index,
   output logic [bss_pkg::POSE_FLD_W-1:0]        rsp_dest_index,
   output logic [bss_pkg::WEIGHT_W-1:0]          rsp_dest_weight,
   output logic                                  rsp_reused
);
   import bss_pkg::*;

   state_type state_ff, state_in;

   logic [POSE_CNT_W-1:0]     pose_count_ff;
   logic signed [PARAM_W-1:0] bp_ff [MAX_POSES];

   logic signed [PARAM_W-1:0] last_param_ff;
   logic                      last_valid_ff;
   logic                      held_two_ff;
   logic [POSE_IDX_W-1:0]     held_source_ff;
   logic [POSE_IDX_W-1:0]     held_dest_ff;
   logic [WEIGHT_W-1:0]       held_weight_ff;
   logic                      reused_ff;
   logic [POSE_IDX_W-1:0]     idx_ff;
   logic signed [PARAM_W-1:0] prev_bp_ff;

   logic                      rsp_valid_ff;
   logic                      rsp_two_ff;
   logic [POSE_FLD_W-1:0]     rsp_source_ff;
   logic [POSE_FLD_W-1:0]     rsp_dest_ff;
   logic [WEIGHT_W-1:0]       rsp_weight_ff;
   logic                      rsp_reused_ff;

   logic [2:0]                count_field;
   logic [CSR_INDEX_W-1:0]    bp_sel;
   logic                      accept;
   logic                      repeat_hit;
   logic signed [PARAM_W-1:0] cur_bp;
   logic                      scan_ge;
   logic                      scan_single;
   logic                      scan_last;
   logic [POSE_IDX_W-1:0]     last_idx;
   logic                      out_free;
   logic                      div_start;
   logic                      div_done;
   logic [PARAM_W:0]          num_wide;
   logic [PARAM_W:0]          den_wide;
   logic [WEIGHT_FRAC_BITS-1:0] div_quot;

   // Configuration registers.
   assign count_field = csr_wdata[2:0];
   assign bp_sel      = csr_index - CSR_BREAKPOINT_0;

   always_ff @(posedge clock) begin
      if (reset) begin
         pose_count_ff <= POSE_CNT_W'(1);
         for (int i = 0; i < MAX_POSES; i++) begin
            bp_ff[i] <= '0;
         end
      end else if (csr_wr_en) begin
         if (csr_index == CSR_POSE_COUNT) begin
            // A count of zero means one pose; a count above the maximum saturates.
            if (count_field == 3'd0) begin
               pose_count_ff <= POSE_CNT_W'(1);
            end else if ({1'b0, count_field} > 4'(MAX_POSES)) begin
               pose_count_ff <= POSE_CNT_W'(MAX_POSES);
            end else begin
               pose_count_ff <= POSE_CNT_W'(count_field);
            end
         end else if ({1'b0, bp_sel} < (CSR_INDEX_W + 1)'(MAX_POSES)) begin
            bp_ff[bp_sel[POSE_IDX_W-1:0]] <= csr_wdata;
         end
      end
   end

   // Scan datapath: one breakpoint compared against the parameter per cycle.
   assign accept      = req_valid && (state_ff == ST_IDLE);
   assign repeat_hit  = last_valid_ff && (req_blend_param == last_param_ff);
   assign cur_bp      = bp_ff[idx_ff];
   assign scan_ge     = (cur_bp >= last_param_ff);
   assign scan_single = (cur_bp == last_param_ff) || (idx_ff == '0);
   assign last_idx    = POSE_IDX_W'(pose_count_ff - 1'b1);
   assign scan_last   = (idx_ff == last_idx);
   assign out_free    = !rsp_valid_ff || !rsp_stall;
   assign div_start   = (state_ff == ST_SCAN) && scan_ge && !scan_single;

   // The breakpoint below the one found is strictly below the parameter, so
   // both differences are positive and fit in the parameter width.
   assign num_wide = {last_param_ff[PARAM_W-1], last_param_ff} -
                     {prev_bp_ff[PARAM_W-1], prev_bp_ff};
   assign den_wide = {cur_bp[PARAM_W-1], cur_bp} - {prev_bp_ff[PARAM_W-1], prev_bp_ff};

   bss_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (num_wide[PARAM_W-1:0]),
      .den   (den_wide[PARAM_W-1:0]),
      .done  (div_done),
      .quot  (div_quot)
   );

   // Sequencer.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = repeat_hit ? ST_DONE : ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (scan_ge) begin
               state_in = scan_single ? ST_DONE : ST_DIV;
            end else if (scan_last) begin
               state_in = ST_DONE;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign req_stall = (state_ff != ST_IDLE);

   // Held selection and scan state.
   always_ff @(posedge clock) begin
      if (reset) begin
         last_param_ff  <= '0;
         last_valid_ff  <= 1'b0;
         held_two_ff    <= 1'b0;
         held_source_ff <= '0;
         held_dest_ff   <= '0;
         held_weight_ff <= WEIGHT_ONE;
         reused_ff      <= 1'b0;
         idx_ff         <= '0;
         prev_bp_ff     <= '0;
      end else begin
         if (accept) begin
            reused_ff <= repeat_hit;
            if (!repeat_hit) begin
               last_param_ff <= req_blend_param;
               last_valid_ff <= 1'b1;
               idx_ff        <= '0;
            end
         end
         if (state_ff == ST_SCAN) begin
            prev_bp_ff <= cur_bp;
            if (scan_ge) begin
               held_dest_ff <= idx_ff;
               if (scan_single) begin
                  held_two_ff    <= 1'b0;
                  held_source_ff <= '0;
                  held_weight_ff <= WEIGHT_ONE;
               end else begin
                  held_two_ff    <= 1'b1;
                  held_source_ff <= idx_ff - 1'b1;
               end
            end else if (scan_last) begin
               // Above every breakpoint in use: the last pose alone.
               held_two_ff    <= 1'b0;
               held_source_ff <= '0;
               held_dest_ff   <= idx_ff;
               held_weight_ff <= WEIGHT_ONE;
            end else begin
               idx_ff <= idx_ff + 1'b1;
            end
         end
         if (div_done) begin
            held_weight_ff <= {1'b0, div_quot};
         end
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if ((state_ff == ST_DONE) && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if ((state_ff == ST_DONE) && out_free) begin
         rsp_two_ff    <= held_two_ff;
         rsp_source_ff <= POSE_FLD_W'(held_source_ff);
         rsp_dest_ff   <= POSE_FLD_W'(held_dest_ff);
         rsp_weight_ff <= held_weight_ff;
         rsp_reused_ff <= reused_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_two_poses    = rsp_two_ff;
   assign rsp_source_index = rsp_source_ff;
   assign rsp_dest_index   = rsp_dest_ff;
   assign rsp_dest_weight  = rsp_weight_ff;
   assign rsp_reused       = rsp_reused_ff;

endmodule

// ===== dv/bss_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bss_checker
// Watches the register port and both channels of blend_segment_select,
// predicts each response from its own copy of the settings and the held
// selection, and compares every response field by field in order.
// ----------------------------------------------------------------------------
module bss_checker (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_wr_en,
   input  logic [bss_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [bss_pkg::CSR_DATA_W-1:0]        csr_wdata,
   input  logic                                  req_valid,
   input  logic                                  req_stall,
   input  logic signed [bss_pkg::PARAM_W-1:0]    req_blend_param,
   input  logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   input  logic                                  rsp_two_poses,
   input  logic [bss_pkg::POSE_FLD_W-1:0]        rsp_source_index,
   input  logic [bss_pkg::POSE_FLD_W-1:0]        rsp_dest_index,
   input  logic [bss_pkg::WEIGHT_W-1:0]          rsp_dest_weight,
   input  logic                                  rsp_reused,
   output int                                    error_count,
   output int                                    pending_count
);
   import bss_pkg::*;

   typedef struct packed {
      logic                  two_poses;
      logic [POSE_FLD_W-1:0] source_index;
      logic [POSE_FLD_W-1:0] dest_index;
      logic [WEIGHT_W-1:0]   dest_weight;
      logic                  reused;
   } blend_result_type;

   logic [POSE_CNT_W-1:0]     pose_count_q;
   logic signed [PARAM_W-1:0] breakpoint_q [MAX_POSES];
   logic signed [PARAM_W-1:0] prev_param;
   logic                      prev_param_seen;
   blend_result_type          held_selection;
   blend_result_type          expected_blends [$];
   int                        mismatches = 0;

   assign error_count = mismatches;

   task automatic report_mismatch(input string msg);
      $display("ERROR: %0t ns: %s", $time, msg);
      mismatches++;
   endtask

   task automatic check_field(input string name, input longint unsigned got,
                              input longint unsigned want);
      if (got != want)
         report_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
   endtask

   // Scan from pose 0 for the first breakpoint at or above p. The breakpoint
   // before a hit is always below p, so the span of a blend is positive.
   function automatic blend_result_type select_pose_segment(
         input logic signed [PARAM_W-1:0] p);
      blend_result_type sel;
      int               active;
      int               hit;
      int               i;
      longint unsigned  span_num;
      longint unsigned  span_den;
      if (pose_count_q == 0)
         active = 1;
      else if (pose_count_q > MAX_POSES)
         active = MAX_POSES;
      else
         active = int'(pose_count_q);
      hit = active;
      for (i = 0; i < active; i++) begin
         if (hit == active && breakpoint_q[i] >= p)
            hit = i;
      end
      sel = '0;
      sel.dest_weight = WEIGHT_ONE;
      if (hit == active) begin
         sel.dest_index = POSE_FLD_W'(active - 1);
      end else if (breakpoint_q[hit] == p || hit == 0) begin
         sel.dest_index = POSE_FLD_W'(hit);
      end else begin
         span_num = longint'(int'(p) - int'(breakpoint_q[hit - 1]));
         span_den = longint'(int'(breakpoint_q[hit]) - int'(breakpoint_q[hit - 1]));
         sel.two_poses    = 1'b1;
         sel.source_index = POSE_FLD_W'(hit - 1);
         sel.dest_index   = POSE_FLD_W'(hit);
         sel.dest_weight  = WEIGHT_W'((span_num << WEIGHT_FRAC_BITS) / span_den);
      end
      return sel;
   endfunction

   always @(posedge clock) begin : monitor
      blend_result_type want;
      if (reset) begin
         pose_count_q    = POSE_CNT_W'(1);
         for (int i = 0; i < MAX_POSES; i++)
            breakpoint_q[i] = '0;
         prev_param      = '0;
         prev_param_seen = 1'b0;
         held_selection  = '0;
         held_selection.dest_weight = WEIGHT_ONE;
         expected_blends.delete();
      end else begin
         if (csr_wr_en) begin
            if (csr_index == CSR_POSE_COUNT)
               pose_count_q = csr_wdata[POSE_CNT_W-1:0];
            else
               breakpoint_q[csr_index - CSR_BREAKPOINT_0] = csr_wdata;
         end
         if (req_valid && !req_stall) begin
            // A repeated parameter returns the held selection, even across a
            // settings change.
            if (prev_param_seen && req_blend_param == prev_param) begin
               want = held_selection;
               want.reused = 1'b1;
            end else begin
               prev_param      = req_blend_param;
               prev_param_seen = 1'b1;
               held_selection  = select_pose_segment(req_blend_param);
               want            = held_selection;
            end
            expected_blends.insert(expected_blends.size(), want);
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_blends.size() == 0) begin
               report_mismatch("response transaction with no request waiting");
            end else begin
               want = expected_blends.pop_front();
               check_field("two_poses", 64'(rsp_two_poses), 64'(want.two_poses));
               check_field("source_index", 64'(rsp_source_index),
                           64'(want.source_index));
               check_field("dest_index", 64'(rsp_dest_index), 64'(want.dest_index));
               check_field("dest_weight", 64'(rsp_dest_weight), 64'(want.dest_weight));
               check_field("reused", 64'(rsp_reused), 64'(want.reused));
            end
         end
      end
      pending_count <= expected_blends.size();
   end

endmodule

// ===== dv/tb_blend_segment_select.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_blend_segment_select
// Drives blend parameters through blend_segment_select under several
// breakpoint settings: a directed set of edge cases, then random phases with
// random idling on both channels, a long response hold-off and a full drain.
// ----------------------------------------------------------------------------
module tb_blend_segment_select;
   import bss_pkg::*;

   localparam int HOLD_CYCLES    = 300;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int PHASES         = 11;
   localparam int PHASE_ITEMS    = 150;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          csr_wr_en = 1'b0;
   logic [CSR_INDEX_W-1:0]        csr_index = '0;
   logic [CSR_DATA_W-1:0]         csr_wdata = '0;
   logic                          req_valid = 1'b0;
   logic                          req_stall;
   logic signed [PARAM_W-1:0]     req_blend_param = '0;
   logic                          rsp_valid;
   logic                          rsp_stall = 1'b0;
   logic                          rsp_two_poses;
   logic [POSE_FLD_W-1:0]         rsp_source_index;
   logic [POSE_FLD_W-1:0]         rsp_dest_index;
   logic [WEIGHT_W-1:0]           rsp_dest_weight;
   logic                          rsp_reused;

   int                            error_count;
   int                            pending_count;
   int                            req_idle_pct = 6;
   int                            rsp_idle_pct = 6;
   int                            hold_requests = 0;
   int                            hold_served = 0;
   int                            hold_left = 0;
   int                            quiet_cycles = 0;

   logic [POSE_CNT_W-1:0]         count_setting;
   logic signed [PARAM_W-1:0]     bp_setting [MAX_POSES];
   logic signed [PARAM_W-1:0]     last_sent = '0;

   blend_segment_select dut (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_blend_param  (req_blend_param),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_two_poses    (rsp_two_poses),
      .rsp_source_index (rsp_source_index),
      .rsp_dest_index   (rsp_dest_index),
      .rsp_dest_weight  (rsp_dest_weight),
      .rsp_reused       (rsp_reused)
   );

   bss_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_blend_param  (req_blend_param),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_two_poses    (rsp_two_poses),
      .rsp_source_index (rsp_source_index),
      .rsp_dest_index   (rsp_dest_index),
      .rsp_dest_weight  (rsp_dest_weight),
      .rsp_reused       (rsp_reused),
      .error_count      (error_count),
      .pending_count    (pending_count)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Response side: random stalls, plus a long hold-off whenever the stimulus
   // asks for one.
   always @(posedge clock) begin
      if (hold_served != hold_requests) begin
         hold_served = hold_requests;
         hold_left   = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   task automatic send_param(input logic signed [PARAM_W-1:0] value);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_blend_param <= value;
      last_sent        = value;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
   endtask

   // The pending count is checked once it holds the last accepted request.
   task automatic wait_for_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0)
         @(posedge clock);
   endtask

   // The pose count goes out with random upper data bits, which the block
   // must ignore.
   task automatic write_settings();
      csr_wr_en <= 1'b1;
      csr_index <= CSR_POSE_COUNT;
      csr_wdata <= {(CSR_DATA_W - POSE_CNT_W)'($urandom), count_setting};
      @(posedge clock);
      for (int i = 0; i < MAX_POSES; i++) begin
         csr_index <= CSR_BREAKPOINT_0 + CSR_INDEX_W'(i);
         csr_wdata <= bp_setting[i];
         @(posedge clock);
      end
      csr_wr_en <= 1'b0;
   endtask

   function automatic logic signed [PARAM_W-1:0] choose_param();
      int                        roll;
      int                        k;
      logic signed [PARAM_W-1:0] v;
      roll = $urandom_range(99);
      k    = $urandom_range(MAX_POSES - 1);
      if (roll < 20)
         v = bp_setting[k];
      else if (roll < 35)
         v = bp_setting[k] + ($urandom_range(1) ? 16'sd1 : -16'sd1);
      else if (roll < 50)
         v = last_sent;
      else if (roll < 56)
         v = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
      else if (roll < 70)
         v = bp_setting[k] + 16'($urandom_range(512)) - 16'sd256;
      else
         v = 16'($urandom);
      return v;
   endfunction

   initial begin
      int                        phase;
      int                        n;
      int                        k;
      int                        j;
      int                        base;
      logic                      narrow;
      logic signed [PARAM_W-1:0] tmp;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: one pose at zero. The first parameter is always
      // evaluated, then repeated, then taken below and above the only pose.
      send_param(16'sd0);
      send_param(16'sd0);
      send_param(-16'sd1);
      send_param(16'sd5);
      wait_for_results();

      // All seven poses spanning the full parameter range. The first
      // parameter repeats the last one, so the held selection must survive
      // the settings change.
      count_setting = 3'd7;
      bp_setting    = '{16'sh8000, -16'sd20000, -16'sd256, 16'sd0, 16'sd256,
                        16'sd10000, 16'sh7FFF};
      write_settings();
      send_param(16'sd5);
      send_param(16'sh8000);
      send_param(16'sh8001);
      send_param(-16'sd257);
      send_param(-16'sd256);
      send_param(16'sd128);
      send_param(16'sd32766);
      send_param(16'sh7FFF);
      send_param(16'sh7FFF);
      send_param(16'sd10001);
      wait_for_results();

      // A pose count of zero behaves as one pose.
      count_setting = 3'd0;
      bp_setting    = '{16'sd100, 16'sd200, 16'sd300, 16'sd400, 16'sd500,
                        16'sd600, 16'sd700};
      write_settings();
      send_param(16'sd99);
      send_param(16'sd100);
      send_param(16'sd101);
      wait_for_results();

      // Widest possible span between two poses.
      count_setting = 3'd2;
      bp_setting    = '{16'sh8000, 16'sh7FFF, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0};
      write_settings();
      send_param(16'sh8001);
      send_param(16'sd32766);
      send_param(16'sd0);
      wait_for_results();

      // Unsorted breakpoints still use the same forward scan.
      count_setting = 3'd5;
      bp_setting    = '{16'sd500, -16'sd500, 16'sd1000, 16'sd200, 16'sd3000,
                        16'sh8000, 16'sh8000};
      write_settings();
      send_param(16'sd600);
      send_param(16'sd3000);
      send_param(16'sh7FFF);
      send_param(-16'sd600);
      wait_for_results();

      for (phase = 0; phase < PHASES; phase++) begin
         if (phase == 1)
            count_setting = 3'd1;
         else if (phase == 2)
            count_setting = 3'd0;
         else if (phase == 0 || phase == 3)
            count_setting = 3'd7;
         else
            count_setting = 3'($urandom_range(7));

         // Narrow windows put breakpoints close together so that random
         // parameters land between them often.
         narrow = $urandom_range(1);
         base   = $urandom_range(63000);
         for (k = 0; k < MAX_POSES; k++)
            bp_setting[k] = narrow ? 16'(base - 32768 + $urandom_range(2000))
                                   : 16'($urandom);
         if (phase != 4 && $urandom_range(9) != 0) begin
            for (k = 1; k < MAX_POSES; k++) begin
               tmp = bp_setting[k];
               j   = k - 1;
               while (j >= 0 && bp_setting[j] > tmp) begin
                  bp_setting[j + 1] = bp_setting[j];
                  j--;
               end
               bp_setting[j + 1] = tmp;
            end
         end
         write_settings();

         req_idle_pct  = (phase == 3) ? 0 : 6;
         rsp_idle_pct <= (phase == 3) ? 0 : 6;

         for (n = 0; n < PHASE_ITEMS; n++) begin
            if (n == 60 && phase % 4 == 0)
               hold_requests <= hold_requests + 1;
            if (n == 75 && phase == 6)
               wait_for_results();
            send_param(choose_param());
         end
         wait_for_results();
      end

      repeat (40) @(posedge clock);
      if (error_count == 0 && pending_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
